[rtl/pbmo_pkg.sv]
// Package for the pixel blend block: channel constants, blend modes, register map, divide helpers.
package pbmo_pkg;

  localparam int unsigned CHANNEL_BITS = 8;
  localparam int unsigned NUM_CHANNELS = 3;
  localparam int unsigned PIXEL_BITS   = 4 * CHANNEL_BITS;
  localparam int unsigned PROD_BITS    = 2 * CHANNEL_BITS;
  // Doubled product plus rounding offset
  localparam int unsigned DIVIN_BITS   = PROD_BITS + 1;
  // Quotient of a doubled product by the channel maximum
  localparam int unsigned QUOT_BITS    = CHANNEL_BITS + 1;

  localparam logic [CHANNEL_BITS-1:0] CH_MAX   = '1;
  localparam logic [DIVIN_BITS-1:0]   HALF_RND = DIVIN_BITS'((2 ** CHANNEL_BITS - 2) / 2);

  localparam int unsigned ADDR_BITS = 3;
  localparam int unsigned DATA_BITS = 32;

  // Register indexes (word address bit 2)
  localparam logic REG_BLEND_MODE = 1'b0;
  localparam logic REG_OPACITY    = 1'b1;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_MULTIPLY = 2'd1,
    MODE_SCREEN   = 2'd2,
    MODE_OVERLAY  = 2'd3
  } blend_mode_e;

  // Reciprocal estimate of y / 255: (y * 257) >> 16, low by at most one
  function automatic logic [QUOT_BITS-1:0] div255_est(input logic [DIVIN_BITS-1:0] y);
    logic [DIVIN_BITS+8:0] p;
    p = {9'd0, y} * (DIVIN_BITS + 9)'(257);
    return p[DIVIN_BITS+7-:QUOT_BITS];
  endfunction

  // Remainder left by an estimate
  function automatic logic [DIVIN_BITS:0] div255_rem(input logic [DIVIN_BITS-1:0] y,
                                                      input logic [QUOT_BITS-1:0]  q);
    logic [DIVIN_BITS:0] prod;
    prod = ({{(DIVIN_BITS-QUOT_BITS+1){1'b0}}, q} << CHANNEL_BITS)
           - {{(DIVIN_BITS-QUOT_BITS+1){1'b0}}, q};
    return {1'b0, y} - prod;
  endfunction

  // Correct the estimate by one where the remainder reaches the divisor
  function automatic logic [QUOT_BITS-1:0] div255_fix(input logic [DIVIN_BITS-1:0] y,
                                                      input logic [QUOT_BITS-1:0]  q);
    logic [DIVIN_BITS:0] r;
    r = div255_rem(y, q);
    return (r >= (DIVIN_BITS + 1)'(CH_MAX)) ? q + QUOT_BITS'(1) : q;
  endfunction

endpackage

[rtl/pixel_blend_mode_opacity.sv]
// Pixel blend block: separable blend modes with opacity mix, six-stage pipeline.
//
// Usage
//   Input channel: in_valid_i with base_pixel_i and adjusted_pixel_i (ARGB, alpha
//   in the top byte); an item is taken at a clock edge with in_valid_i high and
//   in_stall_o low. Output channel: out_valid_o with result_pixel_o; the item
//   leaves at an edge with out_valid_o high and out_stall_i low.
//   Registers over the APB-style port: 0x0 blend mode (normal, multiply, screen,
//   overlay), 0x4 opacity level (255 = fully blended). Write them while idle.
// Timing
//   One item per cycle is sustained while out_stall_i is low. The six stages are:
//   operand select and channel product, divide estimate, divide correction and
//   mode result, opacity mix products, second divide estimate, second correction
//   and alpha pass-through.
// Reset and stall
//   Reset empties the pipeline and sets mode normal, opacity 255.
//   A stage holds its item while the next one is full and stalled; empty stages
//   keep filling, so a stall loses and repeats nothing. in_stall_o rises only
//   once every stage is full and out_stall_i is high.
module pixel_blend_mode_opacity
  import pbmo_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input item
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIXEL_BITS-1:0] base_pixel_i,
  input  logic [PIXEL_BITS-1:0] adjusted_pixel_i,
  // Output item
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIXEL_BITS-1:0] result_pixel_o,
  // Register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready
);

  localparam int unsigned NSTAGE = 6;
  localparam int unsigned CB     = CHANNEL_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  blend_mode_e       blend_mode_q;
  logic [CB-1:0]     opacity_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_mode_q <= MODE_NORMAL;
      opacity_q    <= CH_MAX;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BLEND_MODE: blend_mode_q <= blend_mode_e'(pwdata[1:0]);
        REG_OPACITY:    opacity_q    <= pwdata[CB-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BLEND_MODE: prdata = {{(DATA_BITS-2){1'b0}}, blend_mode_q};
      REG_OPACITY:    prdata = {{(DATA_BITS-CB){1'b0}}, opacity_q};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its content moves on
  // ---------------------------------------------------------------------------
  logic [NSTAGE:1]   vld_q;
  logic [NSTAGE+1:1] en;

  always_comb begin
    en[NSTAGE+1] = !out_stall_i;
    for (int k = NSTAGE; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) vld_q[1] <= in_valid_i;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  logic [NSTAGE:1][PIXEL_BITS-1:0]        base_q;
  logic [2:1][NUM_CHANNELS-1:0][CB-1:0]   adj_q;
  logic [2:1][NUM_CHANNELS-1:0]           inv_q;
  logic [NUM_CHANNELS-1:0][PROD_BITS-1:0] prod1_q;
  logic                                   dbl1_q;
  logic [2:1]                             norm_q;
  logic [NUM_CHANNELS-1:0][DIVIN_BITS-1:0] y2_q;
  logic [NUM_CHANNELS-1:0][QUOT_BITS-1:0]  est2_q;
  logic [NUM_CHANNELS-1:0][CB-1:0]         v3_q;
  logic [NUM_CHANNELS-1:0][PROD_BITS-1:0]  mix4_q;
  logic [NUM_CHANNELS-1:0][DIVIN_BITS-1:0] y5_q;
  logic [NUM_CHANNELS-1:0][QUOT_BITS-1:0]  est5_q;
  logic [PIXEL_BITS-1:0]                   res6_q;

  // Stage 1 operands: screen and upper overlay work on inverted channels
  logic [NUM_CHANNELS-1:0]           inv_d;
  logic [NUM_CHANNELS-1:0][PROD_BITS-1:0] prod_d;
  logic [NUM_CHANNELS-1:0][CB-1:0]   b_in, a_in, m1, m2;

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      b_in[c]  = base_pixel_i[c*CB +: CB];
      a_in[c]  = adjusted_pixel_i[c*CB +: CB];
      inv_d[c] = (blend_mode_q == MODE_SCREEN) ||
                 ((blend_mode_q == MODE_OVERLAY) && b_in[c][CB-1]);
      m1[c]    = inv_d[c] ? ~b_in[c] : b_in[c];
      m2[c]    = inv_d[c] ? ~a_in[c] : a_in[c];
      prod_d[c] = {{CB{1'b0}}, m1[c]} * {{CB{1'b0}}, m2[c]};
    end
  end

  // Stage 2 dividend, stage 3 mode result
  logic [NUM_CHANNELS-1:0][DIVIN_BITS-1:0] y2_d;
  logic [NUM_CHANNELS-1:0][QUOT_BITS-1:0]  q3;
  logic [NUM_CHANNELS-1:0][CB-1:0]         v3_d;
  logic [NUM_CHANNELS-1:0][DIVIN_BITS:0]   rem3;

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      y2_d[c] = (dbl1_q ? {prod1_q[c], 1'b0} : {1'b0, prod1_q[c]}) + HALF_RND;
      q3[c]   = div255_fix(y2_q[c], est2_q[c]);
      rem3[c] = div255_rem(y2_q[c], q3[c]);
      if (norm_q[2]) v3_d[c] = adj_q[2][c];
      else if (inv_q[2][c]) v3_d[c] = ~q3[c][CB-1:0];
      else v3_d[c] = q3[c][CB-1:0];
    end
  end

  // Stage 4 opacity mix, stage 5 dividend, stage 6 result
  logic [NUM_CHANNELS-1:0][PROD_BITS-1:0]  mix4_d;
  logic [NUM_CHANNELS-1:0][DIVIN_BITS-1:0] y5_d;
  logic [NUM_CHANNELS-1:0][QUOT_BITS-1:0]  q6;
  logic [PIXEL_BITS-1:0]                   res6_d;

  always_comb begin
    res6_d = {base_q[5][PIXEL_BITS-1 -: CB], {(NUM_CHANNELS*CB){1'b0}}};
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      mix4_d[c] = {{CB{1'b0}}, base_q[3][c*CB +: CB]} * {{CB{1'b0}}, ~opacity_q}
                + {{CB{1'b0}}, v3_q[c]} * {{CB{1'b0}}, opacity_q};
      y5_d[c]   = {1'b0, mix4_q[c]} + HALF_RND;
      q6[c]     = div255_fix(y5_q[c], est5_q[c]);
      res6_d[c*CB +: CB] = q6[c][CB-1:0];
    end
    // Zero base alpha passes the base pixel untouched
    if (base_q[5][PIXEL_BITS-1 -: CB] == '0) res6_d = base_q[5];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      base_q[1]  <= base_pixel_i;
      adj_q[1]   <= a_in;
      inv_q[1]   <= inv_d;
      prod1_q    <= prod_d;
      dbl1_q     <= (blend_mode_q == MODE_OVERLAY);
      norm_q[1]  <= (blend_mode_q == MODE_NORMAL);
    end
    if (en[2]) begin
      base_q[2]  <= base_q[1];
      adj_q[2]   <= adj_q[1];
      inv_q[2]   <= inv_q[1];
      norm_q[2]  <= norm_q[1];
      y2_q       <= y2_d;
      for (int c = 0; c < NUM_CHANNELS; c++) est2_q[c] <= div255_est(y2_d[c]);
    end
    if (en[3]) begin
      base_q[3]  <= base_q[2];
      v3_q       <= v3_d;
    end
    if (en[4]) begin
      base_q[4]  <= base_q[3];
      mix4_q     <= mix4_d;
    end
    if (en[5]) begin
      base_q[5]  <= base_q[4];
      y5_q       <= y5_d;
      for (int c = 0; c < NUM_CHANNELS; c++) est5_q[c] <= div255_est(y5_d[c]);
    end
    if (en[6]) begin
      base_q[6]  <= base_q[5];
      res6_q     <= res6_d;
    end
  end

  assign out_valid_o    = vld_q[NSTAGE];
  assign result_pixel_o = res6_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Result alpha always follows the base alpha of the same item
  a_alpha_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NSTAGE] |-> result_pixel_o[PIXEL_BITS-1 -: CB] == base_q[NSTAGE][PIXEL_BITS-1 -: CB])
    else $error("result alpha differs from base alpha");

  // Corrected quotient leaves a remainder below the divisor
  a_div_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (rem3[0] < (DIVIN_BITS + 1)'(CH_MAX)) && (rem3[1] < (DIVIN_BITS + 1)'(CH_MAX))
                 && (rem3[2] < (DIVIN_BITS + 1)'(CH_MAX)))
    else $error("blend divide correction out of range");

  // Input is held back only when the whole pipeline is full and stalled
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q) && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // A stalled output item stays in the last stage
  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NSTAGE] && out_stall_i |=> vld_q[NSTAGE] && $stable(base_q[NSTAGE]))
    else $error("stalled item left the last stage");

endmodule
